/* rtl/core/lsr_pkg.sv */
// Shared constants, types and helpers for the loopback sample ring.
`timescale 1ns / 1ps
package lsr_pkg;

    localparam int RING_DEPTH = 32768;
    localparam int MAX_READ   = 64;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 7;
    localparam int PTR_W    = $clog2(RING_DEPTH);
    localparam int CNT_W    = $clog2(MAX_READ + 1);
    localparam int CMP_W    = (PTR_W > CNT_W) ? PTR_W : CNT_W;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_LOAD
    } t_ctrl_state;

    typedef struct packed {
        logic write;
        logic start_rd;
        logic emit_pad;
        logic issue_rd;
        logic load_data;
    } t_ctrl_cmd;

    typedef struct packed {
        logic req_zero;
        logic pad_pending;
        logic run_done;
        logic out_free;
    } t_dp_status;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(RING_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

endpackage

/* rtl/core/lsr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/lsr_ctrl.sv */
// Controller state machine: sequences write beats, padding and sample reads.
`timescale 1ns / 1ps
module lsr_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_func,
    input  lsr_pkg::t_dp_status    i_status,
    output logic                   o_ready,
    output lsr_pkg::t_ctrl_cmd     o_cmd
);

    lsr_pkg::t_ctrl_state r_state;
    lsr_pkg::t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            lsr_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_func == lsr_pkg::FUNC_WRITE) begin
                        o_cmd.write = 1'b1;
                    end else if (!i_status.req_zero) begin
                        o_cmd.start_rd = 1'b1;
                        n_state        = lsr_pkg::ST_EMIT;
                    end
                end
            end
            lsr_pkg::ST_EMIT: begin
                if (i_status.run_done) begin
                    n_state = lsr_pkg::ST_IDLE;
                end else if (i_status.out_free) begin
                    if (i_status.pad_pending) begin
                        o_cmd.emit_pad = 1'b1;
                    end else begin
                        o_cmd.issue_rd = 1'b1;
                        n_state        = lsr_pkg::ST_LOAD;
                    end
                end
            end
            lsr_pkg::ST_LOAD: begin
                o_cmd.load_data = 1'b1;
                n_state         = lsr_pkg::ST_EMIT;
            end
            default: begin
                n_state = lsr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/lsr_datapath.sv */
// Datapath: ring pointers, fill level, run counters, sample RAM and output register.
`timescale 1ns / 1ps
module lsr_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsr_pkg::t_ctrl_cmd            i_cmd,
    input  logic [lsr_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic [lsr_pkg::COUNT_W-1:0]   i_read_count,
    input  logic                          i_ready,
    output lsr_pkg::t_dp_status           o_status,
    output logic                          o_valid,
    output logic [lsr_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                          o_is_padding,
    output logic                          o_last_of_run
);

    logic [lsr_pkg::PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [lsr_pkg::PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [lsr_pkg::CNT_W-1:0]    r_pad_cnt, n_pad_cnt;
    logic [lsr_pkg::CNT_W-1:0]    r_rem_cnt, n_rem_cnt;
    logic                         r_out_valid, n_out_valid;
    logic [lsr_pkg::SAMPLE_W-1:0] r_sample, n_sample;
    logic                         r_pad, n_pad;
    logic                         r_last, n_last;

    logic [lsr_pkg::PTR_W:0]      diff;
    logic [lsr_pkg::PTR_W-1:0]    fill;
    logic                         full;
    logic [lsr_pkg::CNT_W-1:0]    want;
    logic [lsr_pkg::CMP_W-1:0]    want_x;
    logic [lsr_pkg::CMP_W-1:0]    fill_x;
    logic [lsr_pkg::CMP_W-1:0]    short_x;
    logic [lsr_pkg::SAMPLE_W-1:0] ram_rdata;
    logic                         out_free;
    logic                         rem_one;

    assign diff = {1'b0, r_wr_ptr} - {1'b0, r_rd_ptr};
    assign fill = diff[lsr_pkg::PTR_W]
                ? lsr_pkg::PTR_W'(diff + (lsr_pkg::PTR_W+1)'(lsr_pkg::RING_DEPTH))
                : diff[lsr_pkg::PTR_W-1:0];
    assign full = (fill == lsr_pkg::PTR_W'(lsr_pkg::RING_DEPTH - 1));

    assign want = (i_read_count > lsr_pkg::COUNT_W'(lsr_pkg::MAX_READ))
                ? lsr_pkg::CNT_W'(lsr_pkg::MAX_READ)
                : lsr_pkg::CNT_W'(i_read_count);
    assign want_x  = lsr_pkg::CMP_W'(want);
    assign fill_x  = lsr_pkg::CMP_W'(fill);
    assign short_x = want_x - fill_x;

    assign out_free = !r_out_valid || i_ready;
    assign rem_one  = (r_rem_cnt == lsr_pkg::CNT_W'(1));

    assign o_status.req_zero    = (i_read_count == '0);
    assign o_status.pad_pending = (r_pad_cnt != '0);
    assign o_status.run_done    = (r_rem_cnt == '0);
    assign o_status.out_free    = out_free;

    lsr_ram #(
        .WIDTH (lsr_pkg::SAMPLE_W),
        .DEPTH (lsr_pkg::RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_sample_in),
        .i_re    (i_cmd.issue_rd),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_pad_cnt   = r_pad_cnt;
        n_rem_cnt   = r_rem_cnt;
        n_out_valid = r_out_valid;
        n_sample    = r_sample;
        n_pad       = r_pad;
        n_last      = r_last;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.write) begin
            // drop the oldest sample when full
            if (full) begin
                n_rd_ptr = lsr_pkg::ptr_next(r_rd_ptr);
            end
            n_wr_ptr = lsr_pkg::ptr_next(r_wr_ptr);
        end
        if (i_cmd.start_rd) begin
            n_rem_cnt = want;
            n_pad_cnt = (fill_x < want_x) ? lsr_pkg::CNT_W'(short_x) : '0;
        end
        if (i_cmd.emit_pad) begin
            n_out_valid = 1'b1;
            n_sample    = '0;
            n_pad       = 1'b1;
            n_last      = rem_one;
            n_pad_cnt   = r_pad_cnt - lsr_pkg::CNT_W'(1);
            n_rem_cnt   = r_rem_cnt - lsr_pkg::CNT_W'(1);
        end
        if (i_cmd.issue_rd) begin
            n_rd_ptr = lsr_pkg::ptr_next(r_rd_ptr);
        end
        if (i_cmd.load_data) begin
            n_out_valid = 1'b1;
            n_sample    = ram_rdata;
            n_pad       = 1'b0;
            n_last      = rem_one;
            n_rem_cnt   = r_rem_cnt - lsr_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_pad_cnt   <= '0;
            r_rem_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_pad_cnt   <= n_pad_cnt;
            r_rem_cnt   <= n_rem_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_pad    <= n_pad;
        r_last   <= n_last;
    end

    assign o_valid       = r_out_valid;
    assign o_sample_out  = r_sample;
    assign o_is_padding  = r_pad;
    assign o_last_of_run = r_last;

    a_pad_within_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad_cnt <= r_rem_cnt)
        else $error("padding count exceeds remaining run");

    a_load_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_data |-> $past(i_cmd.issue_rd))
        else $error("data load without a RAM read the cycle before");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_pad || i_cmd.load_data) |-> (!r_out_valid || i_ready))
        else $error("output beat overwritten before it was taken");

    a_pad_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_pad |-> (r_pad_cnt != '0))
        else $error("padding beat with no padding pending");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_pad || i_cmd.load_data) && rem_one |=> o_status.run_done)
        else $error("run did not end after its last beat");

endmodule

/* rtl/core/loopback_sample_ring_core.sv */
// Top level of the loopback sample ring: controller plus datapath.
`timescale 1ns / 1ps
// A write beat stores one 16-bit sample and the core is ready again in
// the next cycle; when the ring already holds RING_DEPTH-1 samples the oldest is
// dropped. A read beat of N samples (saturated to MAX_READ) blocks the input for
// its whole run: padding beats go out at one per cycle while the output register
// is free, each stored sample takes a RAM read and then a load into the output
// register, and a final controller step closes the run.
// A finished beat waits in the output register while a new item is accepted.
// The sample RAM has no reset and needs no clearing.
module loopback_sample_ring_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [lsr_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic [lsr_pkg::COUNT_W-1:0]   i_read_count,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lsr_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                          o_is_padding,
    output logic                          o_last_of_run
);

    lsr_pkg::t_ctrl_cmd  cmd;
    lsr_pkg::t_dp_status status;

    lsr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    lsr_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_sample_in   (i_sample_in),
        .i_read_count  (i_read_count),
        .i_ready       (i_ready),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_sample_out  (o_sample_out),
        .o_is_padding  (o_is_padding),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* test/tb_loopback_sample_ring_core.sv */
// Self-checking testbench for the loopback sample ring core.
`timescale 1ns / 1ps
module tb_loopback_sample_ring_core;

    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RANDOM_ITEMS = 384;

    typedef struct packed {
        logic [lsr_pkg::SAMPLE_W-1:0] sample;
        logic                         padding;
        logic                         run_end;
    } t_ring_beat;

    class t_ring_tracker;
        logic [lsr_pkg::SAMPLE_W-1:0] slots [lsr_pkg::RING_DEPTH];
        logic [lsr_pkg::PTR_W-1:0]    wr_ptr;
        logic [lsr_pkg::PTR_W-1:0]    rd_ptr;
        t_ring_beat                   pending_samples [$];
        int                           errors;

        function new();
            wr_ptr = '0;
            rd_ptr = '0;
            errors = 0;
        endfunction

        function logic [lsr_pkg::PTR_W-1:0] step_ptr(logic [lsr_pkg::PTR_W-1:0] p);
            return lsr_pkg::PTR_W'((int'(p) + 1) % lsr_pkg::RING_DEPTH);
        endfunction

        function int stored();
            if (wr_ptr >= rd_ptr) begin
                return int'(wr_ptr) - int'(rd_ptr);
            end
            return lsr_pkg::RING_DEPTH - int'(rd_ptr) + int'(wr_ptr);
        endfunction

        function void note_beat(logic func, logic [lsr_pkg::SAMPLE_W-1:0] smp,
                                logic [lsr_pkg::COUNT_W-1:0] cnt);
            int         want;
            int         avail;
            int         pad;
            t_ring_beat b;
            if (func == lsr_pkg::FUNC_WRITE) begin
                if (stored() >= lsr_pkg::RING_DEPTH - 1) begin
                    rd_ptr = step_ptr(rd_ptr);
                end
                slots[wr_ptr] = smp;
                wr_ptr = step_ptr(wr_ptr);
            end else begin
                want  = (int'(cnt) > lsr_pkg::MAX_READ) ? lsr_pkg::MAX_READ : int'(cnt);
                avail = stored();
                pad   = (avail < want) ? want - avail : 0;
                for (int k = 0; k < want; k++) begin
                    if (k < pad) begin
                        b.sample  = '0;
                        b.padding = 1'b1;
                    end else begin
                        b.sample  = slots[rd_ptr];
                        b.padding = 1'b0;
                        rd_ptr = step_ptr(rd_ptr);
                    end
                    b.run_end = (k + 1 == want);
                    pending_samples.push_back(b);
                end
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_beat(logic [lsr_pkg::SAMPLE_W-1:0] s, logic p, logic l);
            t_ring_beat exp_b;
            if (pending_samples.size() == 0) begin
                report($sformatf("unexpected beat sample=%h pad=%b last=%b", s, p, l));
                return;
            end
            exp_b = pending_samples.pop_front();
            if (s !== exp_b.sample) begin
                report($sformatf("sample_out %h, want %h", s, exp_b.sample));
            end
            if (p !== exp_b.padding) begin
                report($sformatf("is_padding %b, want %b", p, exp_b.padding));
            end
            if (l !== exp_b.run_end) begin
                report($sformatf("last_of_run %b, want %b", l, exp_b.run_end));
            end
        endtask
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic                         i_func;
    logic [lsr_pkg::SAMPLE_W-1:0] i_sample_in;
    logic [lsr_pkg::COUNT_W-1:0]  i_read_count;
    logic                         o_valid;
    logic                         i_ready;
    logic [lsr_pkg::SAMPLE_W-1:0] o_sample_out;
    logic                         o_is_padding;
    logic                         o_last_of_run;

    t_ring_tracker tracker;
    int            burst_left;
    int            cycle_count;
    int            stall_mode;
    int            stall_left;
    logic [31:0]   stall_mask;

    loopback_sample_ring_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_sample_in   (i_sample_in),
        .i_read_count  (i_read_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_sample_out  (o_sample_out),
        .o_is_padding  (o_is_padding),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_mask = $urandom;
            stall_left = 32;
        end
        stall_left--;
        case (stall_mode)
            0: begin
                i_ready <= 1'b1;
            end
            1: begin
                i_ready <= stall_mask[stall_left];
            end
            default: begin
                i_ready <= (stall_left % 4) != 0;
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tracker.check_beat(o_sample_out, o_is_padding, o_last_of_run);
        end
    end

    task automatic push_item(logic func, logic [lsr_pkg::SAMPLE_W-1:0] smp,
                             logic [lsr_pkg::COUNT_W-1:0] cnt);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_func       <= func;
        i_sample_in  <= smp;
        i_read_count <= cnt;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_beat(func, smp, cnt);
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_samples.size() != 0);
        burst_left = 0;
    endtask

    task automatic run_directed();
        push_item(lsr_pkg::FUNC_READ, 16'hFFFF, 7'd0);
        push_item(lsr_pkg::FUNC_READ, 16'h0000, 7'd1);
        push_item(lsr_pkg::FUNC_READ, 16'h0000, 7'd64);
        push_item(lsr_pkg::FUNC_READ, 16'hFFFF, 7'd127);
        push_item(lsr_pkg::FUNC_WRITE, 16'h0000, 7'd127);
        push_item(lsr_pkg::FUNC_WRITE, 16'hFFFF, 7'd0);
        push_item(lsr_pkg::FUNC_WRITE, 16'h8000, 7'd64);
        push_item(lsr_pkg::FUNC_WRITE, 16'h0001, 7'd1);
        push_item(lsr_pkg::FUNC_WRITE, 16'hA5A5, 7'd85);
        push_item(lsr_pkg::FUNC_READ, 16'hFFFF, 7'd0);
        push_item(lsr_pkg::FUNC_READ, 16'h5A5A, 7'd3);
        push_item(lsr_pkg::FUNC_READ, 16'h0000, 7'd5);
        push_item(lsr_pkg::FUNC_WRITE, 16'h1234, 7'd42);
        push_item(lsr_pkg::FUNC_READ, 16'hFFFF, 7'd65);
        push_item(lsr_pkg::FUNC_WRITE, 16'h5A5A, 7'd0);
        push_item(lsr_pkg::FUNC_WRITE, 16'h7FFF, 7'd127);
        push_item(lsr_pkg::FUNC_WRITE, 16'hFFFE, 7'd3);
        push_item(lsr_pkg::FUNC_READ, 16'h0000, 7'd3);
    endtask

    task automatic run_random();
        int r;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2 || $urandom_range(0, 39) == 0) begin
                hold_until_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 58) begin
                push_item(lsr_pkg::FUNC_WRITE,
                          lsr_pkg::SAMPLE_W'($urandom_range(0, 65535)),
                          lsr_pkg::COUNT_W'($urandom_range(0, 127)));
            end else if (r < 90) begin
                push_item(lsr_pkg::FUNC_READ,
                          lsr_pkg::SAMPLE_W'($urandom_range(0, 65535)),
                          lsr_pkg::COUNT_W'($urandom_range(0, 12)));
            end else begin
                push_item(lsr_pkg::FUNC_READ,
                          lsr_pkg::SAMPLE_W'($urandom_range(0, 65535)),
                          lsr_pkg::COUNT_W'($urandom_range(0, 127)));
            end
        end
    endtask

    // drain the ring with saturated reads, then refill a little and overdraw it
    task automatic run_tail();
        repeat (3) begin
            push_item(lsr_pkg::FUNC_READ, lsr_pkg::SAMPLE_W'($urandom_range(0, 65535)),
                      lsr_pkg::COUNT_W'(lsr_pkg::MAX_READ));
        end
        repeat (4) begin
            push_item(lsr_pkg::FUNC_WRITE, lsr_pkg::SAMPLE_W'($urandom_range(0, 65535)),
                      7'd0);
        end
        push_item(lsr_pkg::FUNC_READ, 16'h0000, 7'd127);
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_func       <= lsr_pkg::FUNC_WRITE;
        i_sample_in  <= '0;
        i_read_count <= '0;
        tracker    = new();
        burst_left = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        run_tail();
        hold_until_drained();
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_samples.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* loopback_sample_ring_core.f */
rtl/core/lsr_pkg.sv
rtl/core/lsr_ram.sv
rtl/core/lsr_ctrl.sv
rtl/core/lsr_datapath.sv
rtl/core/loopback_sample_ring_core.sv
test/tb_loopback_sample_ring_core.sv
